>>> hw/rtl/spps_pkg.sv
// shared types and constants for the staggered periodic poll scheduler
// field widths, operation codes, register map and controller/datapath structs
// no dependencies
package spps_pkg;

    localparam int GROUPS_DEF = 8;

    localparam int OP_W   = 2;
    localparam int NOW_W  = 32;
    localparam int GI_W   = 3;
    localparam int IV_W   = 16;
    localparam int ID_W   = 29;
    localparam int LEN_W  = 7;

    localparam int MAX_LEN   = 64;
    localparam int MAX_POLLS = 8;
    localparam int HIT_W     = $clog2(MAX_POLLS + 1);

    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESCHED = 2'd2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_EXT_IDX = 1'b0;

    typedef struct packed {
        logic capture;
        logic wr_entry;
        logic cnt_step;
        logic ptr_clr;
        logic sched_plain;
        logic mul_load;
        logic div_start;
        logic sched_div_wr;
        logic tick_hit;
        logic tick_skip;
        logic tick_flush;
    } spps_cmd_t;

    typedef struct packed {
        logic ptr_end;
        logic active;
        logic multi;
        logic hit;
        logic pend_valid;
        logic out_free;
        logic full;
        logic div_done;
    } spps_status_t;

endpackage

>>> hw/rtl/spps_div.sv
// restoring divider, one quotient bit per cycle
// used for the reschedule offset; depends on nothing
module spps_div #(
    parameter int DIVIDEND_W = 20,
    parameter int DIVISOR_W  = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);
    localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;
    logic [DIVISOR_W-1:0]  rem_next;

    always_comb begin
        shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
        ge       = shifted >= {1'b0, divisor};
        diff     = shifted - {1'b0, divisor};
        rem_next = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DIVIDEND_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/spps_datapath.sv
// group table, walk pointer, due-time arithmetic, pending and output beat registers
// depends on spps_pkg and spps_div
module spps_datapath #(
    parameter int GROUPS = spps_pkg::GROUPS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  spps_pkg::spps_cmd_t        cmd,
    output spps_pkg::spps_status_t     status,
    input  logic [spps_pkg::NOW_W-1:0] now_ms,
    input  logic [spps_pkg::GI_W-1:0]  group_index,
    input  logic [spps_pkg::IV_W-1:0]  interval_ms,
    input  logic [spps_pkg::ID_W-1:0]  frame_id,
    input  logic [spps_pkg::LEN_W-1:0] payload_bytes,
    input  logic                       ext_id,
    input  logic                       m_ready,
    output logic                       m_valid,
    output logic [spps_pkg::GI_W-1:0]  m_poll_group,
    output logic [spps_pkg::ID_W-1:0]  m_poll_frame_id,
    output logic [spps_pkg::LEN_W-1:0] m_poll_length,
    output logic                       m_extended_id,
    output logic                       m_last_poll
);
    import spps_pkg::*;

    localparam int CNT_W  = $clog2(GROUPS + 1);
    localparam int IDX_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int PROD_W = IV_W + CNT_W;

    logic [IV_W-1:0]  iv_store_reg  [GROUPS];
    logic [ID_W-1:0]  id_store_reg  [GROUPS];
    logic [LEN_W-1:0] len_store_reg [GROUPS];
    logic [NOW_W-1:0] due_store_reg [GROUPS];

    logic [NOW_W-1:0] now_reg;
    logic [GI_W-1:0]  gi_reg;
    logic [IV_W-1:0]  iv_in_reg;
    logic [ID_W-1:0]  id_in_reg;
    logic [LEN_W-1:0] len_in_reg;

    logic [CNT_W-1:0]  ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [HIT_W-1:0]  hits_reg;
    logic [PROD_W-1:0] prod_reg;

    logic             pend_valid_reg;
    logic [GI_W-1:0]  pend_group_reg;
    logic [ID_W-1:0]  pend_id_reg;
    logic [LEN_W-1:0] pend_len_reg;

    logic             m_valid_reg;
    logic [GI_W-1:0]  m_group_reg;
    logic [ID_W-1:0]  m_id_reg;
    logic [LEN_W-1:0] m_len_reg;
    logic             m_ext_reg;
    logic             m_last_reg;

    logic [IV_W-1:0]   rd_iv;
    logic [ID_W-1:0]   rd_id;
    logic [LEN_W-1:0]  rd_len;
    logic [NOW_W-1:0]  rd_due;
    logic              active;
    logic [NOW_W-1:0]  sum_plain;
    logic [NOW_W-1:0]  nxt_raw;
    logic [NOW_W-1:0]  nxt_due;
    logic [NOW_W-1:0]  due_div;
    logic [NOW_W-1:0]  due_wdata;
    logic              due_we;
    logic              push;
    logic              div_done;
    logic [PROD_W-1:0] quot;

    always_comb begin
        rd_iv     = iv_store_reg[ptr_reg[IDX_W-1:0]];
        rd_id     = id_store_reg[ptr_reg[IDX_W-1:0]];
        rd_len    = len_store_reg[ptr_reg[IDX_W-1:0]];
        rd_due    = due_store_reg[ptr_reg[IDX_W-1:0]];
        active    = (rd_iv != '0) && (rd_len != '0) && (rd_len <= LEN_W'(MAX_LEN));
        sum_plain = now_reg + NOW_W'(rd_iv);
        nxt_raw   = rd_due + NOW_W'(rd_iv);
        nxt_due   = (nxt_raw <= now_reg) ? sum_plain : nxt_raw;
        due_div   = now_reg + NOW_W'(quot[IV_W-1:0]);
        due_we    = cmd.sched_plain | cmd.sched_div_wr | cmd.tick_hit;
        if (cmd.sched_div_wr) begin
            due_wdata = due_div;
        end else if (cmd.tick_hit) begin
            due_wdata = nxt_due;
        end else begin
            due_wdata = sum_plain;
        end
        push = (cmd.tick_hit & pend_valid_reg) | cmd.tick_flush;
    end

    always_comb begin
        status.ptr_end    = ptr_reg == CNT_W'(GROUPS);
        status.active     = active;
        status.multi      = cnt_reg > CNT_W'(1);
        status.hit        = active && (now_reg >= rd_due);
        status.pend_valid = pend_valid_reg;
        status.out_free   = !m_valid_reg | m_ready;
        status.full       = hits_reg == HIT_W'(MAX_POLLS);
        status.div_done   = div_done;
    end

    // activity fields reset to zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < GROUPS; g++) begin
                iv_store_reg[g]  <= '0;
                len_store_reg[g] <= '0;
            end
        end else begin
            for (int g = 0; g < GROUPS; g++) begin
                if (cmd.wr_entry && int'(gi_reg) == g) begin
                    iv_store_reg[g]  <= iv_in_reg;
                    len_store_reg[g] <= len_in_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < GROUPS; g++) begin
            if (cmd.wr_entry && int'(gi_reg) == g) begin
                id_store_reg[g]  <= id_in_reg;
                due_store_reg[g] <= now_reg;
            end else if (due_we && ptr_reg == CNT_W'(g)) begin
                due_store_reg[g] <= due_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg        <= '0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            hits_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.capture || cmd.ptr_clr) begin
                ptr_reg <= '0;
            end else if (cmd.cnt_step || cmd.sched_plain || cmd.sched_div_wr ||
                         cmd.tick_hit || cmd.tick_skip) begin
                ptr_reg <= ptr_reg + CNT_W'(1);
            end

            if (cmd.capture) begin
                cnt_reg <= '0;
            end else if (cmd.cnt_step && active) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            if (cmd.capture) begin
                idx_reg <= '0;
            end else if ((cmd.sched_plain && active) || cmd.sched_div_wr) begin
                idx_reg <= idx_reg + CNT_W'(1);
            end

            if (cmd.capture) begin
                hits_reg <= '0;
            end else if (cmd.tick_hit) begin
                hits_reg <= hits_reg + HIT_W'(1);
            end

            if (cmd.capture || cmd.tick_flush) begin
                pend_valid_reg <= 1'b0;
            end else if (cmd.tick_hit) begin
                pend_valid_reg <= 1'b1;
            end

            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            now_reg    <= now_ms;
            gi_reg     <= group_index;
            iv_in_reg  <= interval_ms;
            id_in_reg  <= frame_id;
            len_in_reg <= payload_bytes;
        end
        if (cmd.mul_load) begin
            prod_reg <= PROD_W'(rd_iv) * PROD_W'(idx_reg);
        end
        if (cmd.tick_hit) begin
            pend_group_reg <= GI_W'(ptr_reg);
            pend_id_reg    <= rd_id;
            pend_len_reg   <= rd_len;
        end
        if (push) begin
            m_group_reg <= pend_group_reg;
            m_id_reg    <= pend_id_reg;
            m_len_reg   <= pend_len_reg;
            m_ext_reg   <= ext_id;
            m_last_reg  <= cmd.tick_flush;
        end
    end

    spps_div #(
        .DIVIDEND_W (PROD_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (quot)
    );

    assign m_valid         = m_valid_reg;
    assign m_poll_group    = m_group_reg;
    assign m_poll_frame_id = m_id_reg;
    assign m_poll_length   = m_len_reg;
    assign m_extended_id   = m_ext_reg;
    assign m_last_poll     = m_last_reg;

endmodule

>>> hw/rtl/spps_ctrl.sv
// controller state machine: sequences write, reschedule and tick walks
// depends on spps_pkg
module spps_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic [spps_pkg::OP_W-1:0]    s_operation,
    output logic                         s_ready,
    input  spps_pkg::spps_status_t       status,
    output spps_pkg::spps_cmd_t          cmd
);
    import spps_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_WRITE    = 7'b0000010,
        ST_COUNT    = 7'b0000100,
        ST_SCHED    = 7'b0001000,
        ST_DIV_GO   = 7'b0010000,
        ST_DIV_WAIT = 7'b0100000,
        ST_TICK     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    unique case (s_operation)
                        OP_TICK:    state_next = ST_TICK;
                        OP_WRITE:   state_next = ST_WRITE;
                        OP_RESCHED: state_next = ST_COUNT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE: begin
                cmd.wr_entry = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_COUNT: begin
                if (status.ptr_end) begin
                    cmd.ptr_clr = 1'b1;
                    state_next  = ST_SCHED;
                end else begin
                    cmd.cnt_step = 1'b1;
                end
            end
            ST_SCHED: begin
                if (status.ptr_end) begin
                    state_next = ST_IDLE;
                end else if (status.active && status.multi) begin
                    cmd.mul_load = 1'b1;
                    state_next   = ST_DIV_GO;
                end else begin
                    cmd.sched_plain = 1'b1;
                end
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    cmd.sched_div_wr = 1'b1;
                    state_next       = ST_SCHED;
                end
            end
            ST_TICK: begin
                if (status.ptr_end || status.full) begin
                    if (!status.pend_valid) begin
                        state_next = ST_IDLE;
                    end else if (status.out_free) begin
                        cmd.tick_flush = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else if (status.hit) begin
                    cmd.tick_hit = !status.pend_valid || status.out_free;
                end else begin
                    cmd.tick_skip = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/staggered_periodic_poll_scheduler.sv
// top level of the staggered periodic poll scheduler: register port, controller, datapath
// depends on spps_pkg, spps_ctrl, spps_datapath
//
// usage
//   s_ channel: one beat per item (tick, write group entry, reschedule all)
//   m_ channel: one beat per poll event, m_last_poll marks the final beat of a tick
//   register use_extended_ids at byte address 0, copied into every poll beat
// timing
//   an item is taken only while the controller is idle
//   write: a capture step, then the table write; an unused operation code returns to idle
//   tick: one group entry per cycle unless a held beat stalls the walk, at most 8 beats per tick
//   reschedule: a walk that counts the active groups, then a scheduling walk; each active group
//     waits for the bit-serial offset divider when two or more are active
//   the first beat of a tick is registered when the second due group is found or the walk
//     ends; at most one beat per cycle after that
// reset
//   table interval and length fields cleared (all groups inactive), register cleared, no beat pending
// stall
//   a held m_ beat stops the tick walk at the next due group; the final beat of a
//   tick may still wait in the output register while the next item is taken
module staggered_periodic_poll_scheduler #(
    parameter int GROUPS = spps_pkg::GROUPS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [spps_pkg::OP_W-1:0]       s_operation,
    input  logic [spps_pkg::NOW_W-1:0]      s_now_ms,
    input  logic [spps_pkg::GI_W-1:0]       s_group_index,
    input  logic [spps_pkg::IV_W-1:0]       s_interval_ms,
    input  logic [spps_pkg::ID_W-1:0]       s_frame_id,
    input  logic [spps_pkg::LEN_W-1:0]      s_payload_bytes,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [spps_pkg::GI_W-1:0]       m_poll_group,
    output logic [spps_pkg::ID_W-1:0]       m_poll_frame_id,
    output logic [spps_pkg::LEN_W-1:0]      m_poll_length,
    output logic                            m_extended_id,
    output logic                            m_last_poll,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [spps_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [spps_pkg::APB_DATA_W-1:0] pwdata,
    output logic [spps_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import spps_pkg::*;

    spps_cmd_t    cmd;
    spps_status_t status;
    logic         ext_reg;
    logic         reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[APB_ADDR_W-1:2] == REG_EXT_IDX;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            ext_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_sel) begin
            prdata = APB_DATA_W'(ext_reg);
        end
    end

    spps_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    spps_datapath #(
        .GROUPS (GROUPS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .now_ms          (s_now_ms),
        .group_index     (s_group_index),
        .interval_ms     (s_interval_ms),
        .frame_id        (s_frame_id),
        .payload_bytes   (s_payload_bytes),
        .ext_id          (ext_reg),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_poll_group    (m_poll_group),
        .m_poll_frame_id (m_poll_frame_id),
        .m_poll_length   (m_poll_length),
        .m_extended_id   (m_extended_id),
        .m_last_poll     (m_last_poll)
    );

endmodule

>>> hw/rtl/spps_checker.sv
// port-level checks for the staggered periodic poll scheduler, bound to the top level
// depends on spps_pkg
module spps_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [spps_pkg::GI_W-1:0]       m_poll_group,
    input logic [spps_pkg::ID_W-1:0]       m_poll_frame_id,
    input logic [spps_pkg::LEN_W-1:0]      m_poll_length,
    input logic                            m_extended_id,
    input logic                            m_last_poll,
    input logic                            pready
);
    import spps_pkg::*;

    // reset leaves no beat and an idle input side
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("beat or busy state after reset");

    // every poll beat carries a length in the active range, 1 to MAX_LEN
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_poll_length != '0) && (m_poll_length <= LEN_W'(MAX_LEN)))
        else $error("poll beat with inactive length");

    // a held beat keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_poll_group) &&
            $stable(m_poll_frame_id) && $stable(m_poll_length) &&
            $stable(m_extended_id) && $stable(m_last_poll))
        else $error("held poll beat changed");

    // after a non-final poll beat is taken, another beat follows or the controller is still busy
    a_tick_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_poll |=> m_valid || !s_ready)
        else $error("tick ended without a final beat");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("register port stalled");

endmodule

bind staggered_periodic_poll_scheduler spps_checker u_spps_checker (.*);
